[design/icrt_pkg.sv]
// ----------------------------------------------------------------------------
// icrt_pkg
// Shared constants, codes and types of the inode slot table.
// ----------------------------------------------------------------------------
package icrt_pkg;

	localparam int SLOT_COUNT   = 64;
	localparam int SLOT_W       = $clog2(SLOT_COUNT);
	localparam int SECTOR_BYTES = 512;
	localparam int INODE_BYTES  = 32;
	localparam int INODES_PER_SECTOR =
		(SECTOR_BYTES / INODE_BYTES == 0) ? 1 : SECTOR_BYTES / INODE_BYTES;

	// depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] COUNT_MAX = 8'hFF;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_ALLOC    = 3'd1,
		ST_FULL     = 3'd2,
		ST_NULL     = 3'd3,
		ST_REL_FREE = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CMD_ACQUIRE,
		CMD_RELEASE,
		CMD_NULL,
		CMD_REL_BAD
	} cmd_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_UPD
	} bk_state_t;

	typedef struct packed {
		logic [7:0]  inode_map_sectors;
		logic [15:0] sector_map_sectors;
	} cfg_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] device;
		logic [11:0] inode_number;
		logic [5:0]  slot;
		logic [16:0] disk_sector;
		logic [8:0]  sector_offset;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  slot_out;
		logic [7:0]  ref_count;
		logic [16:0] disk_sector;
		logic [8:0]  sector_offset;
	} result_t;

	typedef struct packed {
		logic [7:0]  count;
		logic [15:0] device;
		logic [11:0] inode_number;
	} entry_t;

endpackage

[design/icrt_front.sv]
// ----------------------------------------------------------------------------
// icrt_front
// Takes requests, classifies them and works out the disk location.
// ----------------------------------------------------------------------------
module icrt_front (
	input  logic               push,
	output logic               full,
	input  logic               op,
	input  logic [15:0]        device,
	input  logic [11:0]        inode_number,
	input  logic [5:0]         slot_in,
	input  icrt_pkg::cfg_t     cfg,
	input  logic               q_full,
	output logic               q_push,
	output icrt_pkg::cmd_t     q_data
);

	logic [11:0] num_m1;
	logic        in_range;

	assign num_m1   = 12'(inode_number - 12'd1);
	assign in_range = (32'(slot_in) < icrt_pkg::SLOT_COUNT);

	assign full   = q_full;
	assign q_push = push && !q_full;

	always_comb begin
		q_data.device        = device;
		q_data.inode_number  = inode_number;
		q_data.slot          = slot_in;
		q_data.disk_sector   = 17'd2 + 17'(cfg.inode_map_sectors)
			+ 17'(cfg.sector_map_sectors)
			+ 17'(num_m1 / icrt_pkg::INODES_PER_SECTOR);
		q_data.sector_offset = 9'((num_m1 % icrt_pkg::INODES_PER_SECTOR)
			* icrt_pkg::INODE_BYTES);
		if (op) begin
			q_data.kind = in_range ? icrt_pkg::CMD_RELEASE : icrt_pkg::CMD_REL_BAD;
		end else if (inode_number == 12'd0) begin
			q_data.kind = icrt_pkg::CMD_NULL;
		end else begin
			q_data.kind = icrt_pkg::CMD_ACQUIRE;
		end
	end

endmodule

[design/icrt_cmd_queue.sv]
// ----------------------------------------------------------------------------
// icrt_cmd_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module icrt_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  icrt_pkg::cmd_t wr_data,
	output logic           q_full,
	input  logic           rd_en,
	output icrt_pkg::cmd_t rd_data,
	output logic           q_empty
);

	icrt_pkg::cmd_t                  slots_q [icrt_pkg::QUEUE_DEPTH];
	logic [icrt_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [icrt_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [icrt_pkg::QUEUE_AW:0]     fill_q;

	assign q_full  = (fill_q == (icrt_pkg::QUEUE_AW + 1)'(icrt_pkg::QUEUE_DEPTH));
	assign q_empty = (fill_q == '0);
	assign rd_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				fill_q <= fill_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[design/icrt_back.sv]
// ----------------------------------------------------------------------------
// icrt_back
// Scans the slot memory, updates counts and holds the result register.
// ----------------------------------------------------------------------------
module icrt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  icrt_pkg::cmd_t    q_data,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output icrt_pkg::result_t res
);

	localparam logic [icrt_pkg::SLOT_W-1:0] LAST_SLOT =
		icrt_pkg::SLOT_W'(icrt_pkg::SLOT_COUNT - 1);

	icrt_pkg::entry_t             mem [icrt_pkg::SLOT_COUNT];
	logic [icrt_pkg::SLOT_COUNT-1:0] used_q;

	icrt_pkg::bk_state_t          state_q, state_d;
	icrt_pkg::cmd_t               cmd_q;
	logic [icrt_pkg::SLOT_W-1:0]  addr_q;
	logic                         issue_done_q;
	icrt_pkg::entry_t             rdata_s1;
	logic [icrt_pkg::SLOT_W-1:0]  chk_idx_s1;
	logic                         chk_vld_s1;
	logic                         have_free_q;
	logic [icrt_pkg::SLOT_W-1:0]  free_idx_q;
	logic                         hit_q;
	logic                         rel_ok_q;
	icrt_pkg::entry_t             upd_ent_q;
	logic [icrt_pkg::SLOT_W-1:0]  upd_idx_q;
	icrt_pkg::result_t            res_q;
	logic                         res_vld_q;

	logic                         is_release;
	logic                         is_direct;
	logic                         used_now;
	logic                         hit_now;
	logic                         chk_end;
	logic                         mem_rd;
	logic                         fire;
	logic                         mem_we;
	logic [icrt_pkg::SLOT_W-1:0]  mem_wa;
	icrt_pkg::entry_t             mem_wd;
	logic                         used_we;
	logic                         used_wd;
	icrt_pkg::result_t            res_d;
	logic [7:0]                   new_count;

	assign is_release = (cmd_q.kind == icrt_pkg::CMD_RELEASE);
	assign is_direct  = (q_data.kind == icrt_pkg::CMD_NULL)
		|| (q_data.kind == icrt_pkg::CMD_REL_BAD);
	assign used_now   = used_q[chk_idx_s1];
	assign hit_now    = !is_release && used_now
		&& (rdata_s1.device == cmd_q.device)
		&& (rdata_s1.inode_number == cmd_q.inode_number);
	// a release reads one slot, an acquire stops on a hit or the last slot
	assign chk_end    = chk_vld_s1 && (is_release || hit_now || chk_idx_s1 == LAST_SLOT);

	always_comb begin
		state_d = state_q;
		case (state_q)
			icrt_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_d = is_direct ? icrt_pkg::BK_UPD : icrt_pkg::BK_SCAN;
				end
			end
			icrt_pkg::BK_SCAN: begin
				if (chk_end) begin
					state_d = icrt_pkg::BK_UPD;
				end
			end
			icrt_pkg::BK_UPD: begin
				if (!res_vld_q || pop) begin
					state_d = icrt_pkg::BK_IDLE;
				end
			end
			default: state_d = icrt_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = (state_q == icrt_pkg::BK_IDLE) && !q_empty;
		mem_rd    = (state_q == icrt_pkg::BK_SCAN) && !issue_done_q;
		fire      = (state_q == icrt_pkg::BK_UPD) && (!res_vld_q || pop);
		mem_we    = 1'b0;
		mem_wa    = upd_idx_q;
		mem_wd    = upd_ent_q;
		used_we   = 1'b0;
		used_wd   = 1'b0;
		new_count = 8'd0;
		res_d.status        = icrt_pkg::ST_NULL;
		res_d.slot_out      = 6'd0;
		res_d.ref_count     = 8'd0;
		res_d.disk_sector   = 17'd0;
		res_d.sector_offset = 9'd0;
		case (cmd_q.kind)
			icrt_pkg::CMD_NULL: begin
				res_d.status = icrt_pkg::ST_NULL;
			end
			icrt_pkg::CMD_REL_BAD: begin
				res_d.status   = icrt_pkg::ST_REL_FREE;
				res_d.slot_out = cmd_q.slot;
			end
			icrt_pkg::CMD_RELEASE: begin
				res_d.slot_out = cmd_q.slot;
				if (rel_ok_q) begin
					new_count       = upd_ent_q.count - 8'd1;
					mem_we          = fire;
					mem_wd.count    = new_count;
					used_we         = fire;
					used_wd         = (new_count != 8'd0);
					res_d.status    = icrt_pkg::ST_HIT;
					res_d.ref_count = new_count;
				end else begin
					res_d.status = icrt_pkg::ST_REL_FREE;
				end
			end
			icrt_pkg::CMD_ACQUIRE: begin
				res_d.disk_sector   = cmd_q.disk_sector;
				res_d.sector_offset = cmd_q.sector_offset;
				if (hit_q) begin
					// count saturates at its top value
					new_count = (upd_ent_q.count == icrt_pkg::COUNT_MAX) ?
						icrt_pkg::COUNT_MAX : upd_ent_q.count + 8'd1;
					mem_we          = fire;
					mem_wd.count    = new_count;
					res_d.status    = icrt_pkg::ST_HIT;
					res_d.slot_out  = 6'(upd_idx_q);
					res_d.ref_count = new_count;
				end else if (have_free_q) begin
					new_count           = 8'd1;
					mem_we              = fire;
					mem_wa              = free_idx_q;
					mem_wd.count        = new_count;
					mem_wd.device       = cmd_q.device;
					mem_wd.inode_number = cmd_q.inode_number;
					used_we             = fire;
					used_wd             = 1'b1;
					res_d.status        = icrt_pkg::ST_ALLOC;
					res_d.slot_out      = 6'(free_idx_q);
					res_d.ref_count     = new_count;
				end else begin
					res_d.status = icrt_pkg::ST_FULL;
				end
			end
			default: res_d.status = icrt_pkg::ST_NULL;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_rd) begin
			rdata_s1 <= mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
		if (mem_rd) begin
			chk_idx_s1 <= addr_q;
		end
		if ((state_q == icrt_pkg::BK_SCAN) && chk_vld_s1) begin
			upd_ent_q <= rdata_s1;
			upd_idx_q <= chk_idx_s1;
			hit_q     <= hit_now;
			rel_ok_q  <= used_now;
		end
		if (fire) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= icrt_pkg::BK_IDLE;
			used_q       <= '0;
			addr_q       <= '0;
			issue_done_q <= 1'b0;
			chk_vld_s1   <= 1'b0;
			have_free_q  <= 1'b0;
			free_idx_q   <= '0;
			res_vld_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				addr_q       <= (q_data.kind == icrt_pkg::CMD_RELEASE) ?
					icrt_pkg::SLOT_W'(q_data.slot) : '0;
				issue_done_q <= 1'b0;
				chk_vld_s1   <= 1'b0;
				have_free_q  <= 1'b0;
			end else begin
				chk_vld_s1 <= mem_rd;
				if (mem_rd) begin
					if (is_release || addr_q == LAST_SLOT) begin
						issue_done_q <= 1'b1;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				// remember the lowest free slot seen so far
				if ((state_q == icrt_pkg::BK_SCAN) && chk_vld_s1 && !is_release
						&& !used_now && !have_free_q) begin
					have_free_q <= 1'b1;
					free_idx_q  <= chk_idx_s1;
				end
			end
			if (used_we) begin
				used_q[mem_wa] <= used_wd;
			end
			if (fire) begin
				res_vld_q <= 1'b1;
			end else if (pop) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	assign empty = !res_vld_q;
	assign res   = res_q;

endmodule

[design/inode_cache_refcount_table_top.sv]
// ----------------------------------------------------------------------------
// inode_cache_refcount_table_top
// Reference-counted inode slot table with disk location lookup.
// ----------------------------------------------------------------------------
// Requests are pushed with push while full is low: op 0 acquires the pair
// (device, inode_number), op 1 releases slot_in. Every request gives one
// result beat, shown while empty is low and taken with pop.
// The front works out the disk sector and offset and queues the request;
// the back reads the 64-entry slot memory one entry a cycle through its
// single read port, an acquire up to a hit or the last entry and a release
// only its own slot, then writes the updated entry; a null inode skips
// the scan. An acquire that misses takes the request from the queue,
// reads every entry, checks the last one and writes. One request is
// worked at a time, so a miss holds the back end for its whole scan; two
// more requests can wait in the command queue.
// The user must write the two map sizes through the APB-style port at byte
// addresses 0 and 4 only while idle; the block itself does not enforce it.
// Reset clears every slot to free and sets both map sizes to one; no
// clearing pass is needed. If the receiver holds off pop the result stays
// in the output register, the back end waits at its next update and
// full rises once the command queue fills.
// ----------------------------------------------------------------------------
module inode_cache_refcount_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [15:0] device,
	input  logic [11:0] inode_number,
	input  logic [5:0]  slot_in,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [5:0]  slot_out,
	output logic [7:0]  ref_count,
	output logic [16:0] disk_sector,
	output logic [8:0]  sector_offset
);

	icrt_pkg::cfg_t    cfg_q;
	icrt_pkg::cmd_t    fr_data;
	icrt_pkg::cmd_t    bk_data;
	icrt_pkg::result_t res;
	logic              fr_push;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inode_map_sectors  <= 8'd1;
			cfg_q.sector_map_sectors <= 16'd1;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				cfg_q.sector_map_sectors <= pwdata[15:0];
			end else begin
				cfg_q.inode_map_sectors <= pwdata[7:0];
			end
		end
	end

	assign prdata = paddr[2] ? {16'd0, cfg_q.sector_map_sectors}
		: {24'd0, cfg_q.inode_map_sectors};

	icrt_front u_front (
		.push         (push),
		.full         (full),
		.op           (op),
		.device       (device),
		.inode_number (inode_number),
		.slot_in      (slot_in),
		.cfg          (cfg_q),
		.q_full       (q_full),
		.q_push       (fr_push),
		.q_data       (fr_data)
	);

	icrt_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fr_push),
		.wr_data (fr_data),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_data (bk_data),
		.q_empty (q_empty)
	);

	icrt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (bk_data),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	assign status        = res.status;
	assign slot_out      = res.slot_out;
	assign ref_count     = res.ref_count;
	assign disk_sector   = res.disk_sector;
	assign sector_offset = res.sector_offset;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the reference-counted inode slot table: requests
// go in through the push/full queue port, every result beat taken with pop is
// checked field by field against a predictor kept in step with the table.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 100;
	localparam int PRINT_LIMIT    = 40;

	localparam logic [2:0] ADDR_INODE_MAP  = 3'd0;
	localparam logic [2:0] ADDR_SECTOR_MAP = 3'd4;

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        push = 1'b0;
	logic        full;
	logic        op = 1'b0;
	logic [15:0] device = '0;
	logic [11:0] inode_number = '0;
	logic [5:0]  slot_in = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  status;
	logic [5:0]  slot_out;
	logic [7:0]  ref_count;
	logic [16:0] disk_sector;
	logic [8:0]  sector_offset;

	// predicted table contents and map sizes
	logic [7:0]  tbl_count [icrt_pkg::SLOT_COUNT];
	logic [15:0] tbl_device [icrt_pkg::SLOT_COUNT];
	logic [11:0] tbl_inode [icrt_pkg::SLOT_COUNT];
	logic [7:0]  map_inode_sectors = 8'd1;
	logic [15:0] map_sector_sectors = 16'd1;

	icrt_pkg::result_t expected_results [$];

	int  mismatches = 0;
	int  requests_sent = 0;
	int  results_seen = 0;
	int  status_tally [8];
	int  pop_hold = 0;
	int  quiet_cycles = 0;
	bit  no_idle = 1'b0;

	inode_cache_refcount_table_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.push          (push),
		.full          (full),
		.op            (op),
		.device        (device),
		.inode_number  (inode_number),
		.slot_in       (slot_in),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.slot_out      (slot_out),
		.ref_count     (ref_count),
		.disk_sector   (disk_sector),
		.sector_offset (sector_offset)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic icrt_pkg::result_t lookup_predict(logic o, logic [15:0] d,
			logic [11:0] n, logic [5:0] s);
		icrt_pkg::result_t r;
		int unsigned       sec;
		int unsigned       off;
		int                i;
		int                free_idx;
		r = '0;
		free_idx = -1;
		if (o == OP_RELEASE) begin
			r.slot_out = s;
			if (tbl_count[s] == 8'd0) begin
				r.status = icrt_pkg::ST_REL_FREE;
			end else begin
				tbl_count[s] = tbl_count[s] - 8'd1;
				r.status = icrt_pkg::ST_HIT;
				r.ref_count = tbl_count[s];
			end
			return r;
		end
		if (n == 12'd0) begin
			r.status = icrt_pkg::ST_NULL;
			return r;
		end
		sec = 2 + int'(map_inode_sectors) + int'(map_sector_sectors)
			+ (int'(n) - 1) / icrt_pkg::INODES_PER_SECTOR;
		off = ((int'(n) - 1) % icrt_pkg::INODES_PER_SECTOR) * icrt_pkg::INODE_BYTES;
		r.disk_sector = 17'(sec);
		r.sector_offset = 9'(off);
		for (i = 0; i < icrt_pkg::SLOT_COUNT; i++) begin
			if (tbl_count[i] != 8'd0) begin
				if (tbl_device[i] == d && tbl_inode[i] == n) begin
					if (tbl_count[i] != icrt_pkg::COUNT_MAX)
						tbl_count[i] = tbl_count[i] + 8'd1;
					r.status = icrt_pkg::ST_HIT;
					r.slot_out = 6'(i);
					r.ref_count = tbl_count[i];
					return r;
				end
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		if (free_idx < 0) begin
			r.status = icrt_pkg::ST_FULL;
			return r;
		end
		tbl_device[free_idx] = d;
		tbl_inode[free_idx] = n;
		tbl_count[free_idx] = 8'd1;
		r.status = icrt_pkg::ST_ALLOC;
		r.slot_out = 6'(free_idx);
		r.ref_count = 8'd1;
		return r;
	endfunction

	function automatic int free_slots();
		int i;
		int cnt;
		cnt = 0;
		for (i = 0; i < icrt_pkg::SLOT_COUNT; i++)
			if (tbl_count[i] == 8'd0)
				cnt++;
		return cnt;
	endfunction

	// scan from a random start for a slot in use
	function automatic bit pick_busy_slot(output logic [5:0] slot);
		int j;
		int start;
		start = $urandom_range(0, icrt_pkg::SLOT_COUNT - 1);
		slot = '0;
		for (j = 0; j < icrt_pkg::SLOT_COUNT; j++) begin
			if (tbl_count[(start + j) % icrt_pkg::SLOT_COUNT] != 8'd0) begin
				slot = 6'((start + j) % icrt_pkg::SLOT_COUNT);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// push stays high after the accepting edge unless a gap follows,
	// so a back-to-back beat never sees push lowered and raised together
	task automatic send_request(input logic o, input logic [15:0] d, input logic [11:0] n,
			input logic [5:0] s);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		op <= o;
		device <= d;
		inode_number <= n;
		slot_in <= s;
		@(posedge clk);
		while (full)
			@(posedge clk);
		expected_results.push_back(lookup_predict(o, d, n, s));
		requests_sent++;
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_check(input logic [2:0] addr, input logic [31:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			report_mismatch($sformatf("register at %0d read %0h want %0h", addr, prdata, want));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// upper data bits are junk and must be dropped by the register
	task automatic set_maps(input logic [7:0] ims, input logic [15:0] sms);
		wait_idle();
		apb_write(ADDR_INODE_MAP, {24'($urandom), ims});
		map_inode_sectors = ims;
		apb_write(ADDR_SECTOR_MAP, {16'($urandom), sms});
		map_sector_sectors = sms;
		apb_check(ADDR_INODE_MAP, {24'd0, ims});
		apb_check(ADDR_SECTOR_MAP, {16'd0, sms});
	endtask

	task automatic random_request(input int acq_pct);
		int          r;
		int          k;
		logic [15:0] d;
		logic [11:0] n;
		logic [5:0]  s;
		logic [5:0]  busy;
		r = $urandom_range(0, 99);
		d = 16'($urandom);
		n = 12'($urandom);
		s = 6'($urandom);
		if (r < 4) begin
			send_request(1'($urandom), d, n, s);
		end else if (r < acq_pct) begin
			k = $urandom_range(0, 9);
			if (k == 0) begin
				n = '0;
			end else if (k < 6 && pick_busy_slot(busy)) begin
				d = tbl_device[busy];
				n = tbl_inode[busy];
			end else begin
				case ($urandom_range(0, 3))
					0: d = 16'h0000;
					1: d = 16'hFFFF;
					2: d = 16'($urandom_range(0, 3));
					default: ;
				endcase
				if (n == 12'd0)
					n = 12'hFFF;
			end
			send_request(OP_ACQUIRE, d, n, s);
		end else begin
			if ($urandom_range(0, 6) != 0)
				void'(pick_busy_slot(s));
			send_request(OP_RELEASE, d, n, s);
		end
	endtask

	task automatic test_directed_requests();
		apb_check(ADDR_INODE_MAP, 32'd1);
		apb_check(ADDR_SECTOR_MAP, 32'd1);
		send_request(OP_ACQUIRE, 16'h1234, 12'h000, 6'h3F);
		send_request(OP_ACQUIRE, 16'h0000, 12'h001, 6'h00);
		send_request(OP_ACQUIRE, 16'hFFFF, 12'hFFF, 6'h15);
		send_request(OP_ACQUIRE, 16'h0000, 12'h001, 6'h2A);
		send_request(OP_ACQUIRE, 16'hFFFF, 12'h001, 6'h00);
		send_request(OP_ACQUIRE, 16'h0000, 12'hFFF, 6'h00);
		// sector boundary: last inode of one sector, first of the next
		send_request(OP_ACQUIRE, 16'hAAAA, 12'h010, 6'h00);
		send_request(OP_ACQUIRE, 16'h5555, 12'h011, 6'h00);
		send_request(OP_RELEASE, 16'h0000, 12'h000, 6'h00);
		send_request(OP_RELEASE, 16'hFFFF, 12'hFFF, 6'h00);
		// release of a slot that is already free
		send_request(OP_RELEASE, 16'h0000, 12'h000, 6'h00);
		send_request(OP_RELEASE, 16'hFFFF, 12'hFFF, 6'h3F);
		// lowest free slot is claimed again
		send_request(OP_ACQUIRE, 16'h0000, 12'h001, 6'h3F);
		send_request(OP_ACQUIRE, 16'hAAAA, 12'h555, 6'h00);
		send_request(OP_ACQUIRE, 16'h5555, 12'hAAA, 6'h00);
		send_request(OP_RELEASE, 16'h0000, 12'h000, 6'h02);
		send_request(OP_RELEASE, 16'h0000, 12'h000, 6'h2A);
	endtask

	task automatic test_map_sizes();
		set_maps(8'h00, 16'h0000);
		send_request(OP_ACQUIRE, 16'h0000, 12'h001, 6'h00);
		send_request(OP_ACQUIRE, 16'h0F0F, 12'hFFF, 6'h00);
		set_maps(8'hFF, 16'hFFFF);
		send_request(OP_ACQUIRE, 16'hF0F0, 12'hFFF, 6'h00);
		send_request(OP_ACQUIRE, 16'hFFFF, 12'h000, 6'h00);
		send_request(OP_RELEASE, 16'hFFFF, 12'hFFF, 6'h01);
	endtask

	task automatic test_count_saturation();
		logic [5:0] slot;
		repeat (258)
			send_request(OP_ACQUIRE, 16'hBEEF, 12'h777, 6'($urandom));
		slot = expected_results[$].slot_out;
		repeat (3)
			send_request(OP_RELEASE, 16'($urandom), 12'($urandom), slot);
	endtask

	task automatic test_table_full();
		logic [5:0] slot;
		while (free_slots() != 0)
			send_request(OP_ACQUIRE, 16'($urandom), 12'($urandom_range(1, 4095)),
				6'($urandom));
		repeat (4)
			send_request(OP_ACQUIRE, 16'($urandom), 12'($urandom_range(1, 4095)),
				6'($urandom));
		send_request(OP_ACQUIRE, 16'h0000, 12'h000, 6'($urandom));
		send_request(OP_ACQUIRE, tbl_device[icrt_pkg::SLOT_COUNT - 1],
			tbl_inode[icrt_pkg::SLOT_COUNT - 1], 6'($urandom));
		slot = 6'd37;
		while (tbl_count[slot] != 8'd0)
			send_request(OP_RELEASE, 16'($urandom), 12'($urandom), slot);
		send_request(OP_ACQUIRE, 16'($urandom), 12'($urandom_range(1, 4095)), 6'($urandom));
	endtask

	task automatic test_random_traffic();
		set_maps(8'($urandom), 16'($urandom));
		repeat (200) random_request(35);
		set_maps(8'hFF, 16'hFFFF);
		repeat (200) random_request(80);
		set_maps(8'h00, 16'h0000);
		no_idle = 1'b1;
		repeat (200) random_request(55);
		set_maps(8'($urandom), 16'($urandom));
		no_idle = 1'b0;
		repeat (200) random_request(55);
	endtask

	always @(posedge clk) begin
		icrt_pkg::result_t want;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected, status %0d slot %0d",
					status, slot_out));
			end else begin
				want = expected_results.pop_front();
				status_tally[want.status]++;
				if (status !== want.status)
					report_mismatch($sformatf("status %0d want %0d", status, want.status));
				if (slot_out !== want.slot_out)
					report_mismatch($sformatf("slot_out %0d want %0d", slot_out, want.slot_out));
				if (ref_count !== want.ref_count)
					report_mismatch($sformatf("ref_count %0d want %0d", ref_count,
						want.ref_count));
				if (disk_sector !== want.disk_sector)
					report_mismatch($sformatf("disk_sector %0d want %0d", disk_sector,
						want.disk_sector));
				if (sector_offset !== want.sector_offset)
					report_mismatch($sformatf("sector_offset %0d want %0d", sector_offset,
						want.sector_offset));
			end
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else begin
			pop <= 1'b1;
			pop_hold = next_gap();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < icrt_pkg::SLOT_COUNT; i++) begin
			tbl_count[i] = '0;
			tbl_device[i] = '0;
			tbl_inode[i] = '0;
		end
		for (int i = 0; i < 8; i++)
			status_tally[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_requests();
		test_map_sizes();
		test_count_saturation();
		test_table_full();
		test_random_traffic();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests, %0d results checked: %0d hit/release, %0d new slot, %0d full,",
			requests_sent, results_seen, status_tally[icrt_pkg::ST_HIT],
			status_tally[icrt_pkg::ST_ALLOC], status_tally[icrt_pkg::ST_FULL]);
		$display("%0d null inode, %0d free-slot release; map sizes at both extremes and random",
			status_tally[icrt_pkg::ST_NULL], status_tally[icrt_pkg::ST_REL_FREE]);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
